FILE: src/fofr_pkg.sv
// Shared types and constants for the frequency-ordered frame replacement block.
// Holds the chain entry and cell control types and the cell operation codes.
// No dependencies.
package fofr_pkg;

  // Sizes of the tracked order and of the fields.
  localparam int NUM_FRAMES = 64;
  localparam int COUNT_BITS = 16;
  localparam int FRAME_W    = 6;

  // Request kinds carried on the input tuser bit.
  localparam logic REQ_ACCESS = 1'b0;
  localparam logic REQ_EVICT  = 1'b1;

  // Operation codes broadcast to every cell of the chain.
  localparam logic [1:0] OP_HOLD   = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_INSERT = 2'd2;
  localparam logic [1:0] OP_POP    = 2'd3;

  // One position of the eviction order.
  typedef struct packed {
    logic                  vld;
    logic [FRAME_W-1:0]    frame;
    logic [COUNT_BITS-1:0] cnt;
  } entry_t;

  // Control broadcast from the sequencer to all cells.
  typedef struct packed {
    logic [1:0]            op;
    logic [FRAME_W-1:0]    key;
    logic [COUNT_BITS-1:0] cnt;
    logic                  hit_any;
    logic                  full;
  } cell_ctl_t;

endpackage

FILE: src/fofr_cell.sv
// One cell of the sorted frame chain: holds one entry of the eviction order.
// Moves data to and from its neighbors under the broadcast control.
// Depends on fofr_pkg.
module fofr_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  fofr_pkg::cell_ctl_t ctl,
  input  fofr_pkg::entry_t   left_ent,
  input  logic               left_keep,
  input  fofr_pkg::entry_t   right_ent,
  input  logic               right_keep,
  input  logic               hs_in,
  output fofr_pkg::entry_t   ent,
  output logic               keep,
  output logic               hs_out,
  output logic               hit_now
);

  fofr_pkg::entry_t ent_r;
  fofr_pkg::entry_t ent_nxt;
  fofr_pkg::entry_t new_ent;
  logic             hit_r;
  logic             hs;

  assign ent     = ent_r;
  assign hit_now = ent_r.vld && (ent_r.frame == ctl.key);

  // An entry stays ahead of the inserted one when its count is not larger.
  assign keep   = ent_r.vld && !hit_r && (ent_r.cnt <= ctl.cnt);
  assign hs     = hs_in | hit_r;
  assign hs_out = hs;

  assign new_ent.vld   = 1'b1;
  assign new_ent.frame = ctl.key;
  assign new_ent.cnt   = ctl.cnt;

  // Next entry: close the gap of a removed entry and open one for the new entry.
  always_comb begin
    ent_nxt = ent_r;
    unique case (ctl.op)
      fofr_pkg::OP_HOLD: begin
        ent_nxt = ent_r;
      end
      fofr_pkg::OP_LOOKUP: begin
        ent_nxt = ent_r;
      end
      fofr_pkg::OP_INSERT: begin
        if (ctl.hit_any) begin
          if (hs) begin
            if (right_keep) begin
              ent_nxt = right_ent;
            end else if (hit_r || keep) begin
              ent_nxt = new_ent;
            end
          end
        end else if (!ctl.full && !keep) begin
          if (left_keep) begin
            ent_nxt = new_ent;
          end else begin
            ent_nxt = left_ent;
          end
        end
      end
      fofr_pkg::OP_POP: begin
        ent_nxt = right_ent;
      end
      default: begin
        ent_nxt = ent_r;
      end
    endcase
  end

  // Entry storage; only the valid bit needs a reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.vld <= 1'b0;
    end else begin
      ent_r.vld <= ent_nxt.vld;
    end
    ent_r.frame <= ent_nxt.frame;
    ent_r.cnt   <= ent_nxt.cnt;
  end

  // Hit flag captured during lookup, used by the following insert.
  always_ff @(posedge clk) begin
    if (ctl.op == fofr_pkg::OP_LOOKUP) begin
      hit_r <= hit_now;
    end
  end

endmodule

FILE: src/frequency_ordered_frame_replacement.sv
// Frame replacement ordered by access count, ties broken by recency of access.
// An access item runs a lookup, then a shift and insert in the cell chain;
// an evict item pops the head and its result is valid in the cycle after acceptance.
// One item at a time is in work; no new item is taken during the update step of an access.
// Synchronous active-low reset empties the order and drops any pending result.
// Depends on fofr_pkg and fofr_cell.
module frequency_ordered_frame_replacement (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [5:0] frame_index, [7:6] zero
  input  logic       in_tuser,   // [0] req_type
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [5:0] victim_frame, [7:6] zero
  output logic       out_tuser   // [0] list_empty
);

  localparam int N = fofr_pkg::NUM_FRAMES;
  localparam int CW = fofr_pkg::COUNT_BITS;
  localparam int FW = fofr_pkg::FRAME_W;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_UPD  = 1'b1;

  localparam logic REQ_ACCESS = fofr_pkg::REQ_ACCESS;
  localparam logic REQ_EVICT  = fofr_pkg::REQ_EVICT;

  logic                state_r, state_nxt;
  logic [FW-1:0]       key_r;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic                hit_any_r;
  logic                out_vld_r;
  logic [FW-1:0]       victim_r;
  logic                empty_r;

  fofr_pkg::cell_ctl_t ctl;
  fofr_pkg::entry_t    ent    [N];
  logic [N-1:0]        keep;
  logic [N-1:0]        hs;
  logic [N-1:0]        hit_now;
  logic [CW-1:0]       sel_cnt;
  logic                in_acc;

  assign in_tready  = (state_r == S_IDLE) && (!out_vld_r || out_tready);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(8 - FW){1'b0}}, victim_r};
  assign out_tuser  = empty_r;

  // Broadcast control for the chain.
  always_comb begin
    ctl.op      = fofr_pkg::OP_HOLD;
    ctl.key     = in_tdata[FW-1:0];
    ctl.cnt     = cnt_r;
    ctl.hit_any = hit_any_r;
    ctl.full    = ent[N-1].vld;
    if (state_r == S_UPD) begin
      ctl.op  = fofr_pkg::OP_INSERT;
      ctl.key = key_r;
    end else if (in_acc) begin
      ctl.op = (in_tuser == REQ_EVICT) ? fofr_pkg::OP_POP : fofr_pkg::OP_LOOKUP;
    end
  end

  // The row of cells; neighbors at the ends see an empty entry.
  for (genvar i = 0; i < N; i++) begin : g_cell
    fofr_pkg::entry_t le, re;
    logic             lk, rk, hin;
    if (i == 0) begin : g_first
      assign le  = '0;
      assign lk  = 1'b1;
      assign hin = 1'b0;
    end else begin : g_mid
      assign le  = ent[i-1];
      assign lk  = keep[i-1];
      assign hin = hs[i-1];
    end
    if (i == N - 1) begin : g_last
      assign re = '0;
      assign rk = 1'b0;
    end else begin : g_inner
      assign re = ent[i+1];
      assign rk = keep[i+1];
    end
    fofr_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .left_ent  (le),
      .left_keep (lk),
      .right_ent (re),
      .right_keep(rk),
      .hs_in     (hin),
      .ent       (ent[i]),
      .keep      (keep[i]),
      .hs_out    (hs[i]),
      .hit_now   (hit_now[i])
    );
  end

  // Count of the matching entry; at most one cell matches.
  always_comb begin
    sel_cnt = '0;
    for (int i = 0; i < N; i++) begin
      sel_cnt = sel_cnt | (hit_now[i] ? ent[i].cnt : '0);
    end
  end

  // New count: one for a new frame, otherwise one more, held at the top value.
  always_comb begin
    if (|hit_now) begin
      cnt_nxt = (&sel_cnt) ? sel_cnt : sel_cnt + 1'b1;
    end else begin
      cnt_nxt = {{(CW - 1){1'b0}}, 1'b1};
    end
  end

  // Sequencer: an access goes to the update step after its lookup.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_tuser == REQ_ACCESS)) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc && (in_tuser == REQ_EVICT)) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Lookup results held for the update step.
  always_ff @(posedge clk) begin
    if (in_acc && (in_tuser == REQ_ACCESS)) begin
      key_r     <= in_tdata[FW-1:0];
      cnt_r     <= cnt_nxt;
      hit_any_r <= |hit_now;
    end
  end

  // Result item of an evict: the head of the order.
  always_ff @(posedge clk) begin
    if (in_acc && (in_tuser == REQ_EVICT)) begin
      victim_r <= ent[0].vld ? ent[0].frame : '0;
      empty_r  <= !ent[0].vld;
    end
  end

endmodule
